// File: hw/rtl/dhist2d_pkg.sv
// shared types and constants for the dithered 2-D histogram
package dhist2d_pkg;

    localparam int DEF_MAX_X_CHANNELS = 256;
    localparam int DEF_MAX_Y_CHANNELS = 256;
    localparam int DEF_VALUE_BITS     = 16;

    localparam int RAW_W      = 16;
    localparam int RND_W      = 7;
    localparam int IDX_W      = 8;
    localparam int COUNT_W    = 16;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int SCALE_W    = 5;

    localparam int QUEUE_DEPTH = 4;

    // dither threshold is (1 - fraction) * 100 <= random
    localparam int DITHER_STEPS = 100;
    // wide enough for (2^31) * 100 and 127 << 31
    localparam int DITHER_W     = 40;
    localparam int FRAC_W       = 32;

    localparam logic [CFG_DATA_W-1:0] RST_X_CHANNELS = CFG_DATA_W'(256);
    localparam logic [CFG_DATA_W-1:0] RST_Y_CHANNELS = CFG_DATA_W'(256);
    localparam logic [SCALE_W-1:0]    RST_X_SCALE    = SCALE_W'(12);
    localparam logic [SCALE_W-1:0]    RST_Y_SCALE    = SCALE_W'(12);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_CHANNELS = 2'd0,
        CFG_Y_CHANNELS = 2'd1,
        CFG_X_SCALE    = 2'd2,
        CFG_Y_SCALE    = 2'd3
    } cfg_index_t;

    localparam logic ACT_INCREMENT = 1'b0;
    localparam logic ACT_READ      = 1'b1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] x_channels;
        logic [CFG_DATA_W-1:0] y_channels;
        logic [SCALE_W-1:0]    x_scale;
        logic [SCALE_W-1:0]    y_scale;
    } cfg_t;

    // flags of a queue entry handed from front to back
    typedef struct packed {
        logic is_read;
        logic hit;
    } entry_flags_t;

    localparam int FLAGS_W = $bits(entry_flags_t);

endpackage

// File: hw/rtl/dhist2d_queue.sv
// small register fifo between the front and back parts
module dhist2d_queue #(
    parameter int WIDTH = 18,
    parameter int DEPTH = dhist2d_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/dhist2d_front.sv
// front part: accepts beats, computes dithered bins and cell addresses
module dhist2d_front #(
    parameter int MAX_X_CHANNELS = dhist2d_pkg::DEF_MAX_X_CHANNELS,
    parameter int MAX_Y_CHANNELS = dhist2d_pkg::DEF_MAX_Y_CHANNELS,
    parameter int VALUE_BITS     = dhist2d_pkg::DEF_VALUE_BITS,
    parameter int ADDR_W         = $clog2(MAX_X_CHANNELS * MAX_Y_CHANNELS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dhist2d_pkg::cfg_t                cfg,
    input  logic                             clear_done,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic [dhist2d_pkg::RAW_W-1:0]    x_value,
    input  logic                             x_present,
    input  logic [dhist2d_pkg::RAW_W-1:0]    y_value,
    input  logic                             y_present,
    input  logic [dhist2d_pkg::RND_W-1:0]    x_random,
    input  logic [dhist2d_pkg::RND_W-1:0]    y_random,
    input  logic [dhist2d_pkg::IDX_W-1:0]    read_column,
    input  logic [dhist2d_pkg::IDX_W-1:0]    read_row,
    input  logic                             queue_full,
    output logic                             push,
    output dhist2d_pkg::entry_flags_t        push_flags,
    output logic [ADDR_W-1:0]                push_addr
);

    localparam int XCH_W  = $clog2(MAX_X_CHANNELS + 1);
    localparam int YCH_W  = $clog2(MAX_Y_CHANNELS + 1);
    localparam int XB_W   = $clog2(MAX_X_CHANNELS);
    localparam int YB_W   = $clog2(MAX_Y_CHANNELS);
    localparam int XCO_W  = VALUE_BITS + XCH_W;
    localparam int YCO_W  = VALUE_BITS + YCH_W;
    localparam int XCL_W  = (XCH_W > dhist2d_pkg::CFG_DATA_W) ? XCH_W : dhist2d_pkg::CFG_DATA_W;
    localparam int YCL_W  = (YCH_W > dhist2d_pkg::CFG_DATA_W) ? YCH_W : dhist2d_pkg::CFG_DATA_W;
    localparam int XRC_W  = (XCH_W > dhist2d_pkg::IDX_W) ? XCH_W : dhist2d_pkg::IDX_W;
    localparam int YRC_W  = (YCH_W > dhist2d_pkg::IDX_W) ? YCH_W : dhist2d_pkg::IDX_W;
    localparam int ROW_W  = YB_W + XCH_W;

    // true when the bin rounds up: (2^scale - frac) * 100 <= rnd * 2^scale
    function automatic logic dither_up(
        input logic [63:0]                      coord,
        input logic [dhist2d_pkg::SCALE_W-1:0]  scale,
        input logic [dhist2d_pkg::RND_W-1:0]    rnd
    );
        logic [dhist2d_pkg::FRAC_W:0]     one;
        logic [dhist2d_pkg::FRAC_W-1:0]   frac;
        logic [dhist2d_pkg::DITHER_W-1:0] lhs;
        logic [dhist2d_pkg::DITHER_W-1:0] rhs;
        one  = (dhist2d_pkg::FRAC_W + 1)'(1) << scale;
        frac = coord[dhist2d_pkg::FRAC_W-1:0] & dhist2d_pkg::FRAC_W'(one - 1'b1);
        lhs  = dhist2d_pkg::DITHER_W'(one - {1'b0, frac})
               * dhist2d_pkg::DITHER_W'(dhist2d_pkg::DITHER_STEPS);
        rhs  = dhist2d_pkg::DITHER_W'(rnd) << scale;
        return lhs <= rhs;
    endfunction

    logic [XCH_W-1:0] xc;
    logic [YCH_W-1:0] yc;
    logic [XCL_W-1:0] xcfg_ext;
    logic [YCL_W-1:0] ycfg_ext;
    logic             adv;

    // stage 1: coordinate products
    logic                          s1_valid_reg;
    logic                          s1_read_reg;
    logic                          s1_both_reg;
    logic [XCO_W-1:0]              s1_xco_reg;
    logic [YCO_W-1:0]              s1_yco_reg;
    logic [dhist2d_pkg::RND_W-1:0] s1_xrnd_reg;
    logic [dhist2d_pkg::RND_W-1:0] s1_yrnd_reg;
    logic [dhist2d_pkg::IDX_W-1:0] s1_col_reg;
    logic [dhist2d_pkg::IDX_W-1:0] s1_row_reg;

    // stage 2: integer part and round-up decision
    logic                          s2_valid_reg;
    logic                          s2_read_reg;
    logic                          s2_both_reg;
    logic [XCO_W-1:0]              s2_xwhole_reg;
    logic [YCO_W-1:0]              s2_ywhole_reg;
    logic                          s2_xup_reg;
    logic                          s2_yup_reg;
    logic [dhist2d_pkg::IDX_W-1:0] s2_col_reg;
    logic [dhist2d_pkg::IDX_W-1:0] s2_row_reg;

    // stage 3: final bins and range check
    logic                          s3_valid_reg;
    logic                          s3_read_reg;
    logic                          s3_hit_reg;
    logic [XB_W-1:0]               s3_xb_reg;
    logic [YB_W-1:0]               s3_yb_reg;

    logic [XCO_W:0]   xbin;
    logic [YCO_W:0]   ybin;
    logic             inc_hit;
    logic             rd_hit;
    logic [ROW_W-1:0] row_base;

    always_comb
    begin
        xcfg_ext = XCL_W'(cfg.x_channels);
        ycfg_ext = YCL_W'(cfg.y_channels);
        xc = (xcfg_ext > XCL_W'(MAX_X_CHANNELS)) ? XCH_W'(MAX_X_CHANNELS) : XCH_W'(xcfg_ext);
        yc = (ycfg_ext > YCL_W'(MAX_Y_CHANNELS)) ? YCH_W'(MAX_Y_CHANNELS) : YCH_W'(ycfg_ext);
    end

    assign adv      = !(s3_valid_reg && queue_full);
    assign in_ready = adv && clear_done;

    always_comb
    begin
        xbin    = (XCO_W + 1)'(s2_xwhole_reg) + (XCO_W + 1)'(s2_xup_reg);
        ybin    = (YCO_W + 1)'(s2_ywhole_reg) + (YCO_W + 1)'(s2_yup_reg);
        inc_hit = s2_both_reg && (xbin < (XCO_W + 1)'(xc)) && (ybin < (YCO_W + 1)'(yc));
        rd_hit  = (XRC_W'(s2_col_reg) < XRC_W'(xc)) && (YRC_W'(s2_row_reg) < YRC_W'(yc));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid && in_ready;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_read_reg <= (action == dhist2d_pkg::ACT_READ);
            s1_both_reg <= x_present && y_present;
            s1_xco_reg  <= XCO_W'(VALUE_BITS'(x_value)) * XCO_W'(xc);
            s1_yco_reg  <= YCO_W'(VALUE_BITS'(y_value)) * YCO_W'(yc);
            s1_xrnd_reg <= x_random;
            s1_yrnd_reg <= y_random;
            s1_col_reg  <= read_column;
            s1_row_reg  <= read_row;

            s2_read_reg   <= s1_read_reg;
            s2_both_reg   <= s1_both_reg;
            s2_xwhole_reg <= s1_xco_reg >> cfg.x_scale;
            s2_ywhole_reg <= s1_yco_reg >> cfg.y_scale;
            s2_xup_reg    <= dither_up(64'(s1_xco_reg), cfg.x_scale, s1_xrnd_reg);
            s2_yup_reg    <= dither_up(64'(s1_yco_reg), cfg.y_scale, s1_yrnd_reg);
            s2_col_reg    <= s1_col_reg;
            s2_row_reg    <= s1_row_reg;

            s3_read_reg <= s2_read_reg;
            if (s2_read_reg)
            begin
                s3_hit_reg <= rd_hit;
                s3_xb_reg  <= XB_W'(s2_col_reg);
                s3_yb_reg  <= YB_W'(s2_row_reg);
            end
            else
            begin
                s3_hit_reg <= inc_hit;
                s3_xb_reg  <= XB_W'(xbin);
                s3_yb_reg  <= YB_W'(ybin);
            end
        end
    end

    // increments that land nowhere are dropped here
    assign row_base           = ROW_W'(s3_yb_reg) * ROW_W'(xc);
    assign push_addr          = ADDR_W'(row_base) + ADDR_W'(s3_xb_reg);
    assign push_flags.is_read = s3_read_reg;
    assign push_flags.hit     = s3_hit_reg;
    assign push               = s3_valid_reg && !queue_full && (s3_read_reg || s3_hit_reg);

endmodule

// File: hw/rtl/dhist2d_back.sv
// back part: count memory with clearing pass, read-modify-write and result register
module dhist2d_back #(
    parameter int MAX_X_CHANNELS = dhist2d_pkg::DEF_MAX_X_CHANNELS,
    parameter int MAX_Y_CHANNELS = dhist2d_pkg::DEF_MAX_Y_CHANNELS,
    parameter int ADDR_W         = $clog2(MAX_X_CHANNELS * MAX_Y_CHANNELS)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  dhist2d_pkg::entry_flags_t          q_flags,
    input  logic [ADDR_W-1:0]                  q_addr,
    output logic                               q_pop,
    output logic                               clear_done,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dhist2d_pkg::COUNT_W-1:0]    cell_count
);

    localparam int STORE_DEPTH = MAX_X_CHANNELS * MAX_Y_CHANNELS;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_WAIT  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [dhist2d_pkg::COUNT_W-1:0] mem [STORE_DEPTH];
    logic [dhist2d_pkg::COUNT_W-1:0] rd_data_reg;

    logic [ADDR_W-1:0]               clr_addr_reg, clr_addr_next;
    dhist2d_pkg::entry_flags_t       cur_flags_reg;
    logic [ADDR_W-1:0]               cur_addr_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [dhist2d_pkg::COUNT_W-1:0] cell_count_reg, cell_count_next;

    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [dhist2d_pkg::COUNT_W-1:0] wr_data;
    logic                            out_free;

    assign out_free   = !out_valid_reg || out_ready;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign clear_done = (state_reg != ST_CLEAR);
    assign out_valid  = out_valid_reg;
    assign cell_count = cell_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cell_count_next = cell_count_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_addr_reg;
        wr_data         = rd_data_reg + 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!cur_flags_reg.is_read)
                begin
                    // counter wraps at the top
                    wr_en      = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    cell_count_next = cur_flags_reg.hit ? rd_data_reg : '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_count_reg <= cell_count_next;
        if (q_pop)
        begin
            cur_flags_reg <= q_flags;
            cur_addr_reg  <= q_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[q_addr];
        end
    end

endmodule

// File: hw/rtl/dithered_2d_histogram.sv
// Dithered 2-D histogram: an increment beat maps its x and y raw values to bins (value times
// channels, scale fractional bits, rounded up when (1 - fraction) * 100 <= random) and bumps
// the cell x + y * x_channels when both are present and in range; a read beat returns one
// cell, or 0 outside the channels. After reset a clearing pass zeroes all MAX_X_CHANNELS *
// MAX_Y_CHANNELS count entries (65536 at the defaults), one entry a cycle, with in_ready low.
// A beat passes through the bin pipeline, then a four-entry queue feeds the memory side,
// where the single-port read-modify-write finishes each beat before it takes the next; that
// port sets the sustained rate. Increments that miss the histogram leave the pipeline without
// using the memory. Registers are to be written only while idle; the block leaves it to the user.
module dithered_2d_histogram #(
    parameter int MAX_X_CHANNELS = dhist2d_pkg::DEF_MAX_X_CHANNELS,
    parameter int MAX_Y_CHANNELS = dhist2d_pkg::DEF_MAX_Y_CHANNELS,
    parameter int VALUE_BITS     = dhist2d_pkg::DEF_VALUE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [dhist2d_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dhist2d_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic [dhist2d_pkg::RAW_W-1:0]        x_value,
    input  logic                                 x_present,
    input  logic [dhist2d_pkg::RAW_W-1:0]        y_value,
    input  logic                                 y_present,
    input  logic [dhist2d_pkg::RND_W-1:0]        x_random,
    input  logic [dhist2d_pkg::RND_W-1:0]        y_random,
    input  logic [dhist2d_pkg::IDX_W-1:0]        read_column,
    input  logic [dhist2d_pkg::IDX_W-1:0]        read_row,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [dhist2d_pkg::COUNT_W-1:0]      cell_count
);

    localparam int ADDR_W = $clog2(MAX_X_CHANNELS * MAX_Y_CHANNELS);
    localparam int ENT_W  = dhist2d_pkg::FLAGS_W + ADDR_W;

    dhist2d_pkg::cfg_t         cfg_reg;
    logic                      clear_done;
    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_empty;
    dhist2d_pkg::entry_flags_t push_flags;
    logic [ADDR_W-1:0]         push_addr;
    logic [ENT_W-1:0]          push_data;
    logic [ENT_W-1:0]          pop_data;
    dhist2d_pkg::entry_flags_t q_flags;
    logic [ADDR_W-1:0]         q_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_channels <= dhist2d_pkg::RST_X_CHANNELS;
            cfg_reg.y_channels <= dhist2d_pkg::RST_Y_CHANNELS;
            cfg_reg.x_scale    <= dhist2d_pkg::RST_X_SCALE;
            cfg_reg.y_scale    <= dhist2d_pkg::RST_Y_SCALE;
        end
        else if (cfg_write)
        begin
            unique case (dhist2d_pkg::cfg_index_t'(cfg_index))
                dhist2d_pkg::CFG_X_CHANNELS: cfg_reg.x_channels <= cfg_data;
                dhist2d_pkg::CFG_Y_CHANNELS: cfg_reg.y_channels <= cfg_data;
                dhist2d_pkg::CFG_X_SCALE:
                    cfg_reg.x_scale <= cfg_data[dhist2d_pkg::SCALE_W-1:0];
                dhist2d_pkg::CFG_Y_SCALE:
                    cfg_reg.y_scale <= cfg_data[dhist2d_pkg::SCALE_W-1:0];
            endcase
        end
    end

    dhist2d_front #(
        .MAX_X_CHANNELS (MAX_X_CHANNELS),
        .MAX_Y_CHANNELS (MAX_Y_CHANNELS),
        .VALUE_BITS     (VALUE_BITS),
        .ADDR_W         (ADDR_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .clear_done  (clear_done),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .x_value     (x_value),
        .x_present   (x_present),
        .y_value     (y_value),
        .y_present   (y_present),
        .x_random    (x_random),
        .y_random    (y_random),
        .read_column (read_column),
        .read_row    (read_row),
        .queue_full  (q_full),
        .push        (q_push),
        .push_flags  (push_flags),
        .push_addr   (push_addr)
    );

    assign push_data = {push_flags, push_addr};

    dhist2d_queue #(
        .WIDTH (ENT_W),
        .DEPTH (dhist2d_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign q_flags = dhist2d_pkg::entry_flags_t'(pop_data[ENT_W-1 -: dhist2d_pkg::FLAGS_W]);
    assign q_addr  = pop_data[ADDR_W-1:0];

    dhist2d_back #(
        .MAX_X_CHANNELS (MAX_X_CHANNELS),
        .MAX_Y_CHANNELS (MAX_Y_CHANNELS),
        .ADDR_W         (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_flags    (q_flags),
        .q_addr     (q_addr),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_count (cell_count)
    );

    // no beat taken while the count memory is still being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done |-> !in_ready)
        else $error("input beat offered ready during clearing pass");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("pop from empty queue");

    // a finished clearing pass never restarts without reset
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        clear_done |=> clear_done)
        else $error("clearing pass restarted");

endmodule

// File: tb/dithered_2d_histogram_tb.sv
// self-checking testbench for the dithered 2-D histogram: directed and random tests
module dithered_2d_histogram_tb;
    import dhist2d_pkg::*;

    localparam int STORE_CELLS   = DEF_MAX_X_CHANNELS * DEF_MAX_Y_CHANNELS;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_BEATS   = 100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic             action;
        logic [RAW_W-1:0] x_value;
        logic             x_present;
        logic [RAW_W-1:0] y_value;
        logic             y_present;
        logic [RND_W-1:0] x_random;
        logic [RND_W-1:0] y_random;
        logic [IDX_W-1:0] read_column;
        logic [IDX_W-1:0] read_row;
    } hist_beat_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  action      = ACT_INCREMENT;
    logic [RAW_W-1:0]      x_value     = '0;
    logic                  x_present   = 1'b0;
    logic [RAW_W-1:0]      y_value     = '0;
    logic                  y_present   = 1'b0;
    logic [RND_W-1:0]      x_random    = '0;
    logic [RND_W-1:0]      y_random    = '0;
    logic [IDX_W-1:0]      read_column = '0;
    logic [IDX_W-1:0]      read_row    = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b1;
    logic [COUNT_W-1:0]    cell_count;

    // predicted histogram and register state
    logic [COUNT_W-1:0]    model_counts [STORE_CELLS];
    logic [CFG_DATA_W-1:0] model_x_channels = RST_X_CHANNELS;
    logic [CFG_DATA_W-1:0] model_y_channels = RST_Y_CHANNELS;
    logic [SCALE_W-1:0]    model_x_scale    = RST_X_SCALE;
    logic [SCALE_W-1:0]    model_y_scale    = RST_Y_SCALE;
    logic [COUNT_W-1:0]    expected_counts [$];

    int          fail_count    = 0;
    int          beats_sent    = 0;
    int          reads_checked = 0;
    int          cycle_count   = 0;
    int unsigned stall_left    = 0;
    int unsigned stall_draw    = 0;
    logic        idle_on       = 1'b1;

    dithered_2d_histogram i_dut (.*);

    always #5 clk = ~clk;

    function automatic int unsigned channels_used(logic [CFG_DATA_W-1:0] chans,
                                                  int unsigned limit);
        return (chans > limit) ? limit : chans;
    endfunction

    function automatic logic [63:0] dithered_bin(logic [RAW_W-1:0] raw, int unsigned chans,
                                                 logic [SCALE_W-1:0] scale,
                                                 logic [RND_W-1:0] rnd);
        logic [63:0] coord;
        logic [63:0] one;
        logic [63:0] frac;
        coord = 64'(raw) * 64'(chans);
        one   = 64'd1 << scale;
        frac  = coord & (one - 64'd1);
        // (1 - fraction) * 100 <= random, scaled by 2^scale to stay exact
        if ((one - frac) * 64'(DITHER_STEPS) <= 64'(rnd) * one)
            return (coord >> scale) + 64'd1;
        return coord >> scale;
    endfunction

    function automatic void predict_beat(hist_beat_t b);
        int unsigned xc;
        int unsigned yc;
        logic [63:0] x_bin;
        logic [63:0] y_bin;
        xc = channels_used(model_x_channels, DEF_MAX_X_CHANNELS);
        yc = channels_used(model_y_channels, DEF_MAX_Y_CHANNELS);
        if (b.action == ACT_READ)
        begin
            if (b.read_column < xc && b.read_row < yc)
                expected_counts.push_back(model_counts[b.read_column + b.read_row * xc]);
            else
                expected_counts.push_back('0);
        end
        else if (b.x_present && b.y_present)
        begin
            x_bin = dithered_bin(b.x_value, xc, model_x_scale, b.x_random);
            y_bin = dithered_bin(b.y_value, yc, model_y_scale, b.y_random);
            if (x_bin < xc && y_bin < yc)
                model_counts[x_bin + y_bin * xc] += 1'b1;
        end
    endfunction

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void check_count(logic [COUNT_W-1:0] got);
        logic [COUNT_W-1:0] want;
        if (expected_counts.size() == 0)
        begin
            report_failure($sformatf("cell_count %0d with no read pending", got));
            return;
        end
        want = expected_counts.pop_front();
        reads_checked++;
        if (got !== want)
            report_failure($sformatf("cell_count expected %0d, got %0d", want, got));
    endfunction

    function automatic hist_beat_t increment_beat(logic [RAW_W-1:0] xv, logic xp,
                                                  logic [RAW_W-1:0] yv, logic yp,
                                                  logic [RND_W-1:0] xr, logic [RND_W-1:0] yr);
        hist_beat_t b;
        b.action      = ACT_INCREMENT;
        b.x_value     = xv;
        b.x_present   = xp;
        b.y_value     = yv;
        b.y_present   = yp;
        b.x_random    = xr;
        b.y_random    = yr;
        // unused fields still toggle
        b.read_column = IDX_W'($urandom);
        b.read_row    = IDX_W'($urandom);
        return b;
    endfunction

    function automatic hist_beat_t read_beat(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
        hist_beat_t b;
        b = increment_beat(RAW_W'($urandom), 1'($urandom), RAW_W'($urandom), 1'($urandom),
                           RND_W'($urandom), RND_W'($urandom));
        b.action      = ACT_READ;
        b.read_column = col;
        b.read_row    = row;
        return b;
    endfunction

    // raw value that lands on or near a chosen bin, sometimes pure noise
    function automatic logic [RAW_W-1:0] aimed_value(int unsigned chans,
                                                     logic [SCALE_W-1:0] scale);
        logic [63:0] target;
        if (chans == 0 || $urandom_range(0, 9) == 0)
            return RAW_W'($urandom_range(0, 65535));
        target = (64'($urandom_range(0, chans)) << scale)
                 + (64'($urandom) & ((64'd1 << scale) - 64'd1));
        target = target / chans;
        return (target > 64'hFFFF) ? 16'hFFFF : target[RAW_W-1:0];
    endfunction

    function automatic logic [RND_W-1:0] pick_dither();
        if ($urandom_range(0, 7) == 0)
            return RND_W'($urandom_range(100, 127));
        return RND_W'($urandom_range(0, 99));
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(int unsigned chans);
        if ($urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, 255));
        return IDX_W'($urandom_range(0, (chans > 255) ? 255 : chans));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_channels();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'(256);
            2: return CFG_DATA_W'($urandom_range(257, 511));
            3: return CFG_DATA_W'(1);
            default: return CFG_DATA_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SCALE_W'(16);
            2: return SCALE_W'($urandom_range(17, 31));
            default: return SCALE_W'($urandom_range(1, 15));
        endcase
    endfunction

    task automatic send_beat(hist_beat_t b);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= b.action;
        x_value     <= b.x_value;
        x_present   <= b.x_present;
        y_value     <= b.y_value;
        y_present   <= b.y_present;
        x_random    <= b.x_random;
        y_random    <= b.y_random;
        read_column <= b.read_column;
        read_row    <= b.read_row;
        do
            @(posedge clk);
        while (!in_ready);
        predict_beat(b);
        beats_sent++;
    endtask

    // increments leave no trace at the output, so let the pipeline settle as well
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(logic [CFG_DATA_W-1:0] x_chans, logic [CFG_DATA_W-1:0] y_chans,
                               logic [SCALE_W-1:0] x_shift, logic [SCALE_W-1:0] y_shift);
        cfg_write <= 1'b1;
        cfg_index <= CFG_X_CHANNELS;
        cfg_data  <= x_chans;
        @(posedge clk);
        cfg_index <= CFG_Y_CHANNELS;
        cfg_data  <= y_chans;
        @(posedge clk);
        cfg_index <= CFG_X_SCALE;
        cfg_data  <= CFG_DATA_W'(x_shift);
        @(posedge clk);
        cfg_index <= CFG_Y_SCALE;
        cfg_data  <= CFG_DATA_W'(y_shift);
        @(posedge clk);
        cfg_write <= 1'b0;
        model_x_channels = x_chans;
        model_y_channels = y_chans;
        model_x_scale    = x_shift;
        model_y_scale    = y_shift;
        @(posedge clk);
    endtask

    task automatic test_cleared_store();
        send_beat(read_beat(8'd0, 8'd0));
        send_beat(read_beat(8'd255, 8'd255));
        send_beat(read_beat(8'd17, 8'd200));
    endtask

    // default registers: 256 channels, 12 fractional bits
    task automatic test_dither_rounding();
        send_beat(increment_beat(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 7'd99, 7'd99));
        send_beat(increment_beat(16'd16, 1'b1, 16'd0, 1'b1, 7'd0, 7'd0));
        send_beat(increment_beat(16'd16, 1'b0, 16'd0, 1'b1, 7'd0, 7'd0));
        send_beat(increment_beat(16'd16, 1'b1, 16'd0, 1'b0, 7'd0, 7'd0));
        // fraction one half: rounds up from 50
        send_beat(increment_beat(16'd8, 1'b1, 16'd0, 1'b1, 7'd50, 7'd0));
        send_beat(increment_beat(16'd8, 1'b1, 16'd0, 1'b1, 7'd49, 7'd0));
        // dither above 99 always rounds up
        send_beat(increment_beat(16'd0, 1'b1, 16'd0, 1'b1, 7'd127, 7'd127));
        send_beat(read_beat(8'd1, 8'd0));
        send_beat(read_beat(8'd0, 8'd0));
        send_beat(read_beat(8'd1, 8'd1));
    endtask

    task automatic test_channel_limits();
        wait_for_idle();
        load_config(9'd4, 9'd3, 5'd2, 5'd2);
        // store kept across the change, now addressed with four columns
        send_beat(read_beat(8'd1, 8'd0));
        send_beat(increment_beat(16'd3, 1'b1, 16'd2, 1'b1, 7'd0, 7'd0));
        send_beat(read_beat(8'd3, 8'd2));
        send_beat(read_beat(8'd4, 8'd0));
        send_beat(read_beat(8'd0, 8'd3));
        wait_for_idle();
        load_config(9'd0, 9'd5, 5'd12, 5'd12);
        send_beat(increment_beat(16'd0, 1'b1, 16'd0, 1'b1, 7'd0, 7'd0));
        send_beat(read_beat(8'd0, 8'd0));
        wait_for_idle();
        // channel counts above the maximum, scales above sixteen
        load_config(9'd511, 9'd300, 5'd31, 5'd17);
        send_beat(increment_beat(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 7'd127, 7'd127));
        send_beat(read_beat(8'd255, 8'd255));
        send_beat(read_beat(8'd1, 8'd1));
    endtask

    task automatic test_random_traffic();
        hist_beat_t  b;
        int unsigned xc;
        int unsigned yc;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_idle();
            load_config(pick_channels(), pick_channels(), pick_scale(), pick_scale());
            idle_on = ($urandom_range(0, 3) != 0);
            xc = channels_used(model_x_channels, DEF_MAX_X_CHANNELS);
            yc = channels_used(model_y_channels, DEF_MAX_Y_CHANNELS);
            repeat (PHASE_BEATS)
            begin
                if ($urandom_range(0, 4) == 0)
                    b = read_beat(pick_index(xc), pick_index(yc));
                else
                    b = increment_beat(aimed_value(xc, model_x_scale),
                                       1'($urandom_range(0, 9) != 0),
                                       aimed_value(yc, model_y_scale),
                                       1'($urandom_range(0, 9) != 0),
                                       pick_dither(), pick_dither());
                send_beat(b);
            end
        end
        idle_on = 1'b1;
    endtask

    // result side: check every returned count, then draw a stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_count(cell_count);
            stall_draw = idle_on ? $urandom_range(0, 10) : 0;
            if (stall_draw != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_draw;
            end
        end
        else if (!out_ready)
        begin
            if (stall_left > 1)
                stall_left <= stall_left - 1;
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reads outstanding", cycle_count,
                     expected_counts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        foreach (model_counts[i])
            model_counts[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_cleared_store();
        test_dither_rounding();
        test_channel_limits();
        test_random_traffic();
        wait_for_idle();
        $display("%0d beats sent across cleared-store, dither, channel-limit and random tests",
                 beats_sent);
        $display("%0d cell reads compared, %0d failures", reads_checked, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dhist2d_pkg.sv
hw/rtl/dhist2d_queue.sv
hw/rtl/dhist2d_front.sv
hw/rtl/dhist2d_back.sv
hw/rtl/dithered_2d_histogram.sv
tb/dithered_2d_histogram_tb.sv
